// ----- hdl/tcw_pkg.sv -----
// ----------------------------------------------------------------------------
// tcw_pkg: shared types and constants of the text console writer
// Operation, character and command codes, the command word handed from the
// front end to the executor, and the tab stop table builder.
// ----------------------------------------------------------------------------
package tcw_pkg;

   localparam int DEF_SCREEN_COLUMNS = 80;
   localparam int DEF_SCREEN_ROWS    = 25;
   localparam int DEF_TAB_WIDTH      = 4;

   localparam int OP_W       = 2;
   localparam int CHAR_W     = 8;
   localparam int ROW_OUT_W  = 5;
   localparam int COL_OUT_W  = 7;
   localparam int DATA_W     = 16;
   localparam int COLOR_W    = 4;
   localparam int ATTR_W     = 2 * COLOR_W;
   localparam int ROW_CMP_W  = ROW_OUT_W + 1;
   localparam int COL_CMP_W  = COL_OUT_W + 1;

   localparam int CSR_INDEX_W = 2;
   localparam logic [CSR_INDEX_W-1:0] REG_FOREGROUND = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_BACKGROUND = 2'd1;
   localparam logic [COLOR_W-1:0] FOREGROUND_RESET = 4'd7;
   localparam logic [COLOR_W-1:0] BACKGROUND_RESET = 4'd0;

   localparam logic [OP_W-1:0] OP_CHAR   = 2'd0;
   localparam logic [OP_W-1:0] OP_LOCATE = 2'd1;
   localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;
   localparam logic [OP_W-1:0] OP_READ   = 2'd3;

   localparam logic [CHAR_W-1:0] CHAR_CR  = 8'd13;
   localparam logic [CHAR_W-1:0] CHAR_LF  = 8'd10;
   localparam logic [CHAR_W-1:0] CHAR_BS  = 8'd8;
   localparam logic [CHAR_W-1:0] CHAR_TAB = 8'd9;

   localparam int KIND_W = 3;
   localparam logic [KIND_W-1:0] KIND_CR     = 3'd0;
   localparam logic [KIND_W-1:0] KIND_LF     = 3'd1;
   localparam logic [KIND_W-1:0] KIND_BS     = 3'd2;
   localparam logic [KIND_W-1:0] KIND_TAB    = 3'd3;
   localparam logic [KIND_W-1:0] KIND_PUT    = 3'd4;
   localparam logic [KIND_W-1:0] KIND_LOCATE = 3'd5;
   localparam logic [KIND_W-1:0] KIND_CLEAR  = 3'd6;
   localparam logic [KIND_W-1:0] KIND_READ   = 3'd7;

   localparam int QUEUE_DEPTH = 2;

   typedef struct packed {
      logic [KIND_W-1:0]    kind;
      logic                 is_text;
      logic                 nl_after;
      logic                 bad;
      logic [CHAR_W-1:0]    char_code;
      logic [ROW_OUT_W-1:0] target_row;
      logic [COL_OUT_W-1:0] target_col;
   } cmd_type;

   localparam int TAB_TABLE_DEPTH = 1 << COL_OUT_W;
   localparam int TAB_STOP_W      = COL_OUT_W + 1;

   typedef logic [TAB_STOP_W-1:0] tab_table_type [TAB_TABLE_DEPTH];

   // Entry i holds the first multiple of the tab width above column i.
   function automatic tab_table_type tab_stop_table(input int tab);
      tab_table_type t;
      int stop;
      stop = tab;
      for (int i = 0; i < TAB_TABLE_DEPTH; i++) begin
         if (i == stop) begin
            stop = stop + tab;
         end
         t[i] = TAB_STOP_W'(stop);
      end
      return t;
   endfunction

endpackage

// ----- hdl/text_console_writer.sv -----
// ----------------------------------------------------------------------------
// text_console_writer: text mode console engine
// Character grid with cursor, scrolling, clear, locate and cell read.
//
//   channel  direction  handshake              word
//   req_     in         req_valid / req_stall  operation, character, position
//   rsp_     out        rsp_valid / rsp_stall  cursor, read data, status
//   csr_     in         csr_valid / csr_ready  register index, write data
//
// A printable character passes a scroll check, execution and a newline step; a
// control character adds a second check, a string end with line feed a newline
// step and a check, each scroll a repeat of the check, and the first write to
// a cleared row a wipe of the row. The executor takes the next word once the
// response is gone. Reset clears the row valid bits at once: no clearing pass.
// Up to two request words wait in the queue while a response is stalled.
// ----------------------------------------------------------------------------
module text_console_writer #(
   parameter int SCREEN_COLUMNS = tcw_pkg::DEF_SCREEN_COLUMNS,
   parameter int SCREEN_ROWS    = tcw_pkg::DEF_SCREEN_ROWS,
   parameter int TAB_WIDTH      = tcw_pkg::DEF_TAB_WIDTH
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [tcw_pkg::OP_W-1:0]        req_operation,
   input  logic [tcw_pkg::CHAR_W-1:0]      req_char_code,
   input  logic                            req_end_of_string,
   input  logic                            req_add_newline,
   input  logic [tcw_pkg::ROW_OUT_W-1:0]   req_target_row,
   input  logic [tcw_pkg::COL_OUT_W-1:0]   req_target_col,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [tcw_pkg::ROW_OUT_W-1:0]   rsp_cursor_row,
   output logic [tcw_pkg::COL_OUT_W-1:0]   rsp_cursor_col,
   output logic [tcw_pkg::DATA_W-1:0]      rsp_read_data,
   output logic                            rsp_status,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [tcw_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [tcw_pkg::COLOR_W-1:0]     csr_data
);
   import tcw_pkg::*;

   logic [COLOR_W-1:0] foreground_ff, foreground_in;
   logic [COLOR_W-1:0] background_ff, background_in;
   logic               push_valid;
   cmd_type            push_word;
   logic               queue_full;
   logic               pop_valid;
   cmd_type            pop_word;
   logic               pop_take;

   assign csr_ready = 1'b1;

   always_comb begin
      foreground_in = foreground_ff;
      background_in = background_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            REG_FOREGROUND: foreground_in = csr_data;
            REG_BACKGROUND: background_in = csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         foreground_ff <= FOREGROUND_RESET;
         background_ff <= BACKGROUND_RESET;
      end else begin
         foreground_ff <= foreground_in;
         background_ff <= background_in;
      end
   end

   tcw_front #(
      .SCREEN_COLUMNS (SCREEN_COLUMNS),
      .SCREEN_ROWS    (SCREEN_ROWS)
   ) u_front (
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_operation     (req_operation),
      .req_char_code     (req_char_code),
      .req_end_of_string (req_end_of_string),
      .req_add_newline   (req_add_newline),
      .req_target_row    (req_target_row),
      .req_target_col    (req_target_col),
      .queue_full        (queue_full),
      .push_valid        (push_valid),
      .push_word         (push_word)
   );

   tcw_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_word  (push_word),
      .queue_full (queue_full),
      .pop_valid  (pop_valid),
      .pop_word   (pop_word),
      .pop_take   (pop_take)
   );

   tcw_back #(
      .SCREEN_COLUMNS (SCREEN_COLUMNS),
      .SCREEN_ROWS    (SCREEN_ROWS),
      .TAB_WIDTH      (TAB_WIDTH)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .pop_valid      (pop_valid),
      .pop_word       (pop_word),
      .pop_take       (pop_take),
      .attribute      ({background_ff, foreground_ff}),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_cursor_row (rsp_cursor_row),
      .rsp_cursor_col (rsp_cursor_col),
      .rsp_read_data  (rsp_read_data),
      .rsp_status     (rsp_status)
   );

`ifndef SYNTHESIS
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ({1'b0, rsp_cursor_col} < COL_CMP_W'(SCREEN_COLUMNS)))
      else $error("response cursor column beyond the last column");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status) |-> (rsp_read_data == '0))
      else $error("failed request returned nonzero read data");

   assert property (@(posedge clock)
      reset |=> !req_stall)
      else $error("request channel stalled right after reset");
`endif

endmodule

// ----- hdl/tcw_front.sv -----
// ----------------------------------------------------------------------------
// tcw_front: request classifier
// Takes request words, sorts them into command kinds, checks the target
// position against the screen size and pushes the command into the queue.
// ----------------------------------------------------------------------------
module tcw_front #(
   parameter int SCREEN_COLUMNS = tcw_pkg::DEF_SCREEN_COLUMNS,
   parameter int SCREEN_ROWS    = tcw_pkg::DEF_SCREEN_ROWS
) (
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [tcw_pkg::OP_W-1:0]       req_operation,
   input  logic [tcw_pkg::CHAR_W-1:0]     req_char_code,
   input  logic                           req_end_of_string,
   input  logic                           req_add_newline,
   input  logic [tcw_pkg::ROW_OUT_W-1:0]  req_target_row,
   input  logic [tcw_pkg::COL_OUT_W-1:0]  req_target_col,
   input  logic                           queue_full,
   output logic                           push_valid,
   output tcw_pkg::cmd_type               push_word
);
   import tcw_pkg::*;

   logic [KIND_W-1:0] kind;

   always_comb begin
      unique case (req_operation)
         OP_CHAR: begin
            unique case (req_char_code)
               CHAR_CR:  kind = KIND_CR;
               CHAR_LF:  kind = KIND_LF;
               CHAR_BS:  kind = KIND_BS;
               CHAR_TAB: kind = KIND_TAB;
               default:  kind = KIND_PUT;
            endcase
         end
         OP_LOCATE: kind = KIND_LOCATE;
         OP_CLEAR:  kind = KIND_CLEAR;
         default:   kind = KIND_READ;
      endcase
   end

   always_comb begin
      push_word.kind       = kind;
      push_word.is_text    = (req_operation == OP_CHAR);
      push_word.nl_after   = req_end_of_string && req_add_newline;
      push_word.bad        = ({1'b0, req_target_row} >= ROW_CMP_W'(SCREEN_ROWS)) ||
                             ({1'b0, req_target_col} >= COL_CMP_W'(SCREEN_COLUMNS));
      push_word.char_code  = req_char_code;
      push_word.target_row = req_target_row;
      push_word.target_col = req_target_col;
   end

   assign req_stall  = queue_full;
   assign push_valid = req_valid && !queue_full;

endmodule

// ----- hdl/tcw_queue.sv -----
// ----------------------------------------------------------------------------
// tcw_queue: command queue
// A short first-in first-out store of classified commands between the front
// end and the executor.
// ----------------------------------------------------------------------------
module tcw_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   input  tcw_pkg::cmd_type push_word,
   output logic             queue_full,
   output logic             pop_valid,
   output tcw_pkg::cmd_type pop_word,
   input  logic             pop_take
);
   import tcw_pkg::*;

   localparam int PTR_W   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int COUNT_W = $clog2(QUEUE_DEPTH + 1);

   cmd_type             entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [COUNT_W-1:0]  count_ff, count_in;
   logic                do_push, do_pop;

   assign queue_full = (count_ff == COUNT_W'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_word   = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && !queue_full;
   assign do_pop     = pop_take && pop_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + COUNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - COUNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_word;
      end
   end

endmodule

// ----- hdl/tcw_back.sv -----
// ----------------------------------------------------------------------------
// tcw_back: command executor
// Holds the cell memory, the cursor and the row map, carries out one command
// at a time and drives the response register. Rows are kept as a ring: a
// scroll moves the top row pointer and drops the old top row.
// ----------------------------------------------------------------------------
module tcw_back #(
   parameter int SCREEN_COLUMNS = tcw_pkg::DEF_SCREEN_COLUMNS,
   parameter int SCREEN_ROWS    = tcw_pkg::DEF_SCREEN_ROWS,
   parameter int TAB_WIDTH      = tcw_pkg::DEF_TAB_WIDTH
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           pop_valid,
   input  tcw_pkg::cmd_type               pop_word,
   output logic                           pop_take,
   input  logic [tcw_pkg::ATTR_W-1:0]     attribute,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [tcw_pkg::ROW_OUT_W-1:0]  rsp_cursor_row,
   output logic [tcw_pkg::COL_OUT_W-1:0]  rsp_cursor_col,
   output logic [tcw_pkg::DATA_W-1:0]     rsp_read_data,
   output logic                           rsp_status
);
   import tcw_pkg::*;

   localparam int CELLS  = SCREEN_ROWS * SCREEN_COLUMNS;
   localparam int ADDR_W = $clog2(CELLS);
   localparam int COL_W  = $clog2(SCREEN_COLUMNS);
   localparam int PROW_W = $clog2(SCREEN_ROWS);
   localparam int LINE_W = $clog2(SCREEN_ROWS + 2);
   localparam logic [PROW_W:0] ROWS_EXT = (PROW_W + 1)'(SCREEN_ROWS);
   localparam tab_table_type TAB_TABLE = tab_stop_table(TAB_WIDTH);

   localparam int STATE_W = 3;
   localparam logic [STATE_W-1:0] S_IDLE = 3'd0;
   localparam logic [STATE_W-1:0] S_PRE  = 3'd1;
   localparam logic [STATE_W-1:0] S_EXEC = 3'd2;
   localparam logic [STATE_W-1:0] S_WIPE = 3'd3;
   localparam logic [STATE_W-1:0] S_FIX  = 3'd4;
   localparam logic [STATE_W-1:0] S_NL   = 3'd5;
   localparam logic [STATE_W-1:0] S_READ = 3'd6;
   localparam logic [STATE_W-1:0] S_DONE = 3'd7;

   logic [DATA_W-1:0]      mem [CELLS];
   logic [DATA_W-1:0]      rd_data_ff;
   logic                   mem_we;
   logic [ADDR_W-1:0]      mem_waddr;
   logic [DATA_W-1:0]      mem_wdata;
   logic [ADDR_W-1:0]      rd_addr;

   logic [STATE_W-1:0]     state_ff, state_in;
   cmd_type                cmd_ff, cmd_in;
   logic [LINE_W-1:0]      line_ff, line_in;
   logic [COL_W-1:0]       col_ff, col_in;
   logic [PROW_W-1:0]      base_ff, base_in;
   logic [SCREEN_ROWS-1:0] row_valid_ff, row_valid_in;
   logic [COL_W-1:0]       wipe_col_ff, wipe_col_in;
   logic                   nl_ff, nl_in;
   logic                   rd_ok_ff, rd_ok_in;
   logic [DATA_W-1:0]      res_data_ff, res_data_in;
   logic                   res_status_ff, res_status_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [ROW_OUT_W-1:0]   rsp_row_ff, rsp_row_in;
   logic [COL_OUT_W-1:0]   rsp_col_ff, rsp_col_in;
   logic [DATA_W-1:0]      rsp_data_ff, rsp_data_in;
   logic                   rsp_status_ff, rsp_status_in;

   logic [PROW_W-1:0]      logical_row;
   logic [PROW_W:0]        prow_sum;
   logic [PROW_W-1:0]      prow;
   logic [ADDR_W-1:0]      row_base_addr;
   logic [COL_OUT_W-1:0]   tab_index;
   logic [TAB_STOP_W-1:0]  tab_next;
   logic                   need_scroll;

   always_comb begin
      if (state_ff == S_EXEC && cmd_ff.kind == KIND_READ) begin
         logical_row = PROW_W'(cmd_ff.target_row);
      end else begin
         logical_row = PROW_W'(line_ff);
      end
      prow_sum = {1'b0, base_ff} + {1'b0, logical_row};
      prow     = (prow_sum >= ROWS_EXT) ? PROW_W'(prow_sum - ROWS_EXT) : PROW_W'(prow_sum);
      row_base_addr = ADDR_W'(prow) * ADDR_W'(SCREEN_COLUMNS);
      tab_index   = COL_OUT_W'(col_ff);
      tab_next    = TAB_TABLE[tab_index];
      need_scroll = (line_ff >= LINE_W'(SCREEN_ROWS));
   end

   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      line_in       = line_ff;
      col_in        = col_ff;
      base_in       = base_ff;
      row_valid_in  = row_valid_ff;
      wipe_col_in   = wipe_col_ff;
      nl_in         = nl_ff;
      rd_ok_in      = rd_ok_ff;
      res_data_in   = res_data_ff;
      res_status_in = res_status_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_row_in    = rsp_row_ff;
      rsp_col_in    = rsp_col_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_status_in = rsp_status_ff;
      pop_take      = 1'b0;
      mem_we        = 1'b0;
      mem_waddr     = row_base_addr + ADDR_W'(col_ff);
      mem_wdata     = {attribute, cmd_ff.char_code};
      rd_addr       = row_base_addr + ADDR_W'(cmd_ff.target_col);

      unique case (state_ff)
         S_IDLE: begin
            if (pop_valid && !rsp_valid_ff) begin
               pop_take      = 1'b1;
               cmd_in        = pop_word;
               nl_in         = pop_word.nl_after;
               res_data_in   = '0;
               res_status_in = 1'b0;
               state_in      = pop_word.is_text ? S_PRE : S_EXEC;
            end
         end
         S_PRE, S_FIX: begin
            if (need_scroll) begin
               row_valid_in[base_ff] = 1'b0;
               base_in = (base_ff == PROW_W'(SCREEN_ROWS - 1)) ? '0 : base_ff + PROW_W'(1);
               line_in = line_ff - LINE_W'(1);
            end else begin
               state_in = (state_ff == S_PRE) ? S_EXEC : S_NL;
            end
         end
         S_EXEC: begin
            unique case (cmd_ff.kind)
               KIND_CR: begin
                  col_in   = '0;
                  state_in = S_FIX;
               end
               KIND_LF: begin
                  col_in   = '0;
                  line_in  = line_ff + LINE_W'(1);
                  state_in = S_FIX;
               end
               KIND_BS: begin
                  if (col_ff != '0) begin
                     col_in = col_ff - COL_W'(1);
                  end
                  state_in = S_FIX;
               end
               KIND_TAB: begin
                  if (tab_next >= TAB_STOP_W'(SCREEN_COLUMNS)) begin
                     col_in  = '0;
                     line_in = line_ff + LINE_W'(1);
                  end else begin
                     col_in = COL_W'(tab_next);
                  end
                  state_in = S_FIX;
               end
               KIND_PUT: begin
                  if (row_valid_ff[prow]) begin
                     mem_we = 1'b1;
                     if (col_ff == COL_W'(SCREEN_COLUMNS - 1)) begin
                        col_in  = '0;
                        line_in = line_ff + LINE_W'(1);
                     end else begin
                        col_in = col_ff + COL_W'(1);
                     end
                     state_in = S_NL;
                  end else begin
                     wipe_col_in = '0;
                     state_in    = S_WIPE;
                  end
               end
               KIND_LOCATE: begin
                  if (cmd_ff.bad) begin
                     res_status_in = 1'b1;
                  end else begin
                     line_in = LINE_W'(cmd_ff.target_row);
                     col_in  = COL_W'(cmd_ff.target_col);
                  end
                  state_in = S_DONE;
               end
               KIND_CLEAR: begin
                  row_valid_in = '0;
                  line_in      = '0;
                  col_in       = '0;
                  state_in     = S_DONE;
               end
               default: begin
                  if (cmd_ff.bad) begin
                     res_status_in = 1'b1;
                     state_in      = S_DONE;
                  end else begin
                     rd_ok_in = row_valid_ff[prow];
                     state_in = S_READ;
                  end
               end
            endcase
         end
         S_WIPE: begin
            mem_we    = 1'b1;
            mem_waddr = row_base_addr + ADDR_W'(wipe_col_ff);
            mem_wdata = '0;
            if (wipe_col_ff == COL_W'(SCREEN_COLUMNS - 1)) begin
               row_valid_in[prow] = 1'b1;
               state_in           = S_EXEC;
            end else begin
               wipe_col_in = wipe_col_ff + COL_W'(1);
            end
         end
         S_NL: begin
            if (nl_ff) begin
               col_in   = '0;
               line_in  = line_ff + LINE_W'(1);
               nl_in    = 1'b0;
               state_in = S_FIX;
            end else begin
               state_in = S_DONE;
            end
         end
         S_READ: begin
            res_data_in = rd_ok_ff ? rd_data_ff : '0;
            state_in    = S_DONE;
         end
         default: begin
            rsp_valid_in  = 1'b1;
            rsp_row_in    = ROW_OUT_W'(line_ff);
            rsp_col_in    = COL_OUT_W'(col_ff);
            rsp_data_in   = res_data_ff;
            rsp_status_in = res_status_ff;
            state_in      = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         line_ff      <= '0;
         col_ff       <= '0;
         base_ff      <= '0;
         row_valid_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         line_ff      <= line_in;
         col_ff       <= col_in;
         base_ff      <= base_in;
         row_valid_ff <= row_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      wipe_col_ff   <= wipe_col_in;
      nl_ff         <= nl_in;
      rd_ok_ff      <= rd_ok_in;
      res_data_ff   <= res_data_in;
      res_status_ff <= res_status_in;
      rsp_row_ff    <= rsp_row_in;
      rsp_col_ff    <= rsp_col_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_status_ff <= rsp_status_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_cursor_row = rsp_row_ff;
   assign rsp_cursor_col = rsp_col_ff;
   assign rsp_read_data  = rsp_data_ff;
   assign rsp_status     = rsp_status_ff;

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for text_console_writer
// A console mirror predicts the report word for every accepted request word
// and checks each report against the oldest prediction. A directed opening
// covers controls, wrapping, scrolling, range checks and clear; random
// phases follow with changing colors, idle and stall patterns, and one long
// receiver hold-off that backs up the request channel.
// ----------------------------------------------------------------------------

localparam int SCREEN_COLS  = tcw_pkg::DEF_SCREEN_COLUMNS;
localparam int SCREEN_LINES = tcw_pkg::DEF_SCREEN_ROWS;
localparam int TAB_STEP     = tcw_pkg::DEF_TAB_WIDTH;
localparam int CELL_TOTAL   = SCREEN_COLS * SCREEN_LINES;

typedef struct packed {
   logic [tcw_pkg::OP_W-1:0]      operation;
   logic [tcw_pkg::CHAR_W-1:0]    char_code;
   logic                          end_of_string;
   logic                          add_newline;
   logic [tcw_pkg::ROW_OUT_W-1:0] target_row;
   logic [tcw_pkg::COL_OUT_W-1:0] target_col;
} console_req_type;

typedef struct packed {
   logic [tcw_pkg::ROW_OUT_W-1:0] cursor_row;
   logic [tcw_pkg::COL_OUT_W-1:0] cursor_col;
   logic [tcw_pkg::DATA_W-1:0]    read_data;
   logic                          status;
} console_report_type;

class console_board;
   logic [tcw_pkg::DATA_W-1:0]  cells [CELL_TOTAL];
   int unsigned                 line;
   int unsigned                 column;
   logic [tcw_pkg::COLOR_W-1:0] foreground;
   logic [tcw_pkg::COLOR_W-1:0] background;
   console_report_type          reports_due [$];
   int                          mismatches;

   function new();
      foreach (cells[i]) cells[i] = '0;
      line = 0;
      column = 0;
      foreground = tcw_pkg::FOREGROUND_RESET;
      background = tcw_pkg::BACKGROUND_RESET;
      mismatches = 0;
   endfunction

   function void set_register(logic [tcw_pkg::CSR_INDEX_W-1:0] index,
                              logic [tcw_pkg::COLOR_W-1:0] value);
      if (index == tcw_pkg::REG_FOREGROUND) foreground = value;
      else if (index == tcw_pkg::REG_BACKGROUND) background = value;
   endfunction

   function void scroll_pending();
      while (line >= SCREEN_LINES) begin
         for (int i = 0; i < CELL_TOTAL - SCREEN_COLS; i++) cells[i] = cells[i + SCREEN_COLS];
         for (int i = CELL_TOTAL - SCREEN_COLS; i < CELL_TOTAL; i++) cells[i] = '0;
         line--;
      end
   endfunction

   function void line_feed();
      column = 0;
      line++;
      scroll_pending();
   endfunction

   function void put_char(logic [tcw_pkg::CHAR_W-1:0] ch);
      int unsigned next_stop;
      scroll_pending();
      case (ch)
         tcw_pkg::CHAR_CR: column = 0;
         tcw_pkg::CHAR_LF: line_feed();
         tcw_pkg::CHAR_BS: if (column != 0) column--;
         tcw_pkg::CHAR_TAB: begin
            next_stop = column + (TAB_STEP - column % TAB_STEP);
            if (next_stop >= SCREEN_COLS) line_feed();
            else column = next_stop;
         end
         default: begin
            cells[line * SCREEN_COLS + column] = {background, foreground, ch};
            column++;
            if (column >= SCREEN_COLS) begin
               column = 0;
               line++;
            end
         end
      endcase
   endfunction

   function console_report_type advance_console(console_req_type w);
      console_report_type r;
      logic               off_screen;
      r = '0;
      off_screen = (w.target_row >= SCREEN_LINES) || (w.target_col >= SCREEN_COLS);
      case (w.operation)
         tcw_pkg::OP_CHAR: begin
            put_char(w.char_code);
            if (w.end_of_string && w.add_newline) line_feed();
         end
         tcw_pkg::OP_LOCATE: begin
            if (off_screen) begin
               r.status = 1'b1;
            end else begin
               line = 32'(w.target_row);
               column = 32'(w.target_col);
            end
         end
         tcw_pkg::OP_CLEAR: begin
            foreach (cells[i]) cells[i] = '0;
            line = 0;
            column = 0;
         end
         default: begin
            if (off_screen) r.status = 1'b1;
            else r.read_data = cells[w.target_row * SCREEN_COLS + w.target_col];
         end
      endcase
      r.cursor_row = tcw_pkg::ROW_OUT_W'(line);
      r.cursor_col = tcw_pkg::COL_OUT_W'(column);
      return r;
   endfunction

   function void note_request(console_req_type w);
      reports_due.push_back(advance_console(w));
   endfunction

   function void report_failure(string text);
      mismatches++;
      if (mismatches <= 10) $display("%s", text);
   endfunction

   function void check_report(console_report_type got);
      console_report_type want;
      if (reports_due.size() == 0) begin
         report_failure($sformatf("unexpected report word: row %0d col %0d data %h status %b",
                                  got.cursor_row, got.cursor_col, got.read_data, got.status));
         return;
      end
      want = reports_due.pop_front();
      if (got.cursor_row !== want.cursor_row || got.cursor_col !== want.cursor_col ||
          got.read_data !== want.read_data || got.status !== want.status) begin
         report_failure($sformatf({"report mismatch: expected row %0d col %0d data %h ",
                                   "status %b, got row %0d col %0d data %h status %b"},
            want.cursor_row, want.cursor_col, want.read_data, want.status,
            got.cursor_row, got.cursor_col, got.read_data, got.status));
      end
   endfunction
endclass

module testbench;
   import tcw_pkg::*;

   localparam int CYCLE_LIMIT = 800000;
   localparam int LONG_HOLD   = 400;
   localparam int PHASE_ITEMS = 260;
   localparam int SETTLE      = 20;
   localparam int PHASES      = 5;
   localparam int IDLE_PCT  [PHASES] = '{0, 62, 0, 21, 0};
   localparam int STALL_PCT [PHASES] = '{0, 0, 62, 21, 0};
   localparam logic [COLOR_W-1:0] FG_LIST [PHASES] = '{4'd15, 4'd0, 4'd9, 4'd3, 4'd15};
   localparam logic [COLOR_W-1:0] BG_LIST [PHASES] = '{4'd0, 4'd15, 4'd6, 4'd12, 4'd15};

   logic                   clock             = 1'b0;
   logic                   reset             = 1'b1;
   logic                   req_valid         = 1'b0;
   logic                   req_stall;
   logic [OP_W-1:0]        req_operation     = '0;
   logic [CHAR_W-1:0]      req_char_code     = '0;
   logic                   req_end_of_string = 1'b0;
   logic                   req_add_newline   = 1'b0;
   logic [ROW_OUT_W-1:0]   req_target_row    = '0;
   logic [COL_OUT_W-1:0]   req_target_col    = '0;
   logic                   rsp_valid;
   logic                   rsp_stall         = 1'b0;
   logic [ROW_OUT_W-1:0]   rsp_cursor_row;
   logic [COL_OUT_W-1:0]   rsp_cursor_col;
   logic [DATA_W-1:0]      rsp_read_data;
   logic                   rsp_status;
   logic                   csr_valid         = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index         = '0;
   logic [COLOR_W-1:0]     csr_data          = '0;

   console_board board;
   int idle_pct    = 0;
   int stall_pct   = 0;
   int hold_token  = 0;
   int hold_seen   = 0;
   int hold_left   = 0;
   int string_left = 0;
   int cycle_count;

   text_console_writer u_dut (.*);

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (hold_token != hold_seen) begin
         hold_seen = hold_token;
         hold_left = LONG_HOLD;
      end
      if (hold_left != 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (csr_valid && csr_ready) board.set_register(csr_index, csr_data);
         if (req_valid && !req_stall) begin
            board.note_request(console_req_type'{req_operation, req_char_code,
                                                 req_end_of_string, req_add_newline,
                                                 req_target_row, req_target_col});
         end
         if (rsp_valid && !rsp_stall) begin
            board.check_report(console_report_type'{rsp_cursor_row, rsp_cursor_col,
                                                    rsp_read_data, rsp_status});
         end
      end
   end

   initial begin
      for (cycle_count = 0; cycle_count < CYCLE_LIMIT; cycle_count++) @(posedge clock);
      $display("** text_console_writer: FAILED **");
      $finish;
   end

   function automatic console_req_type word_of(logic [OP_W-1:0] op, logic [CHAR_W-1:0] ch,
                                               logic eos, logic nl,
                                               logic [ROW_OUT_W-1:0] row,
                                               logic [COL_OUT_W-1:0] col);
      return console_req_type'{op, ch, eos, nl, row, col};
   endfunction

   function automatic console_req_type random_word();
      console_req_type w;
      int              pick;
      int              near_row;
      w.operation     = OP_CHAR;
      w.char_code     = CHAR_W'($urandom);
      w.end_of_string = 1'($urandom);
      w.add_newline   = 1'($urandom);
      w.target_row    = ROW_OUT_W'($urandom);
      w.target_col    = COL_OUT_W'($urandom);
      pick = $urandom_range(99);
      if (pick < 75) begin
         if (string_left == 0) string_left = ($urandom_range(9) == 0) ?
                                             $urandom_range(80, 200) : $urandom_range(1, 40);
         string_left--;
         w.end_of_string = (string_left == 0);
         w.add_newline = w.end_of_string ? ($urandom_range(99) < 60) : ($urandom_range(99) < 10);
         pick = $urandom_range(99);
         if (pick < 80) begin
            w.char_code = CHAR_W'($urandom_range(32, 126));
         end else if (pick < 92) begin
            case ($urandom_range(3))
               0: w.char_code = CHAR_CR;
               1: w.char_code = CHAR_LF;
               2: w.char_code = CHAR_BS;
               default: w.char_code = CHAR_TAB;
            endcase
         end
      end else if (pick < 87) begin
         w.operation = OP_READ;
         pick = $urandom_range(99);
         if (pick < 45) begin
            near_row = (board.line >= SCREEN_LINES) ? SCREEN_LINES - 1 : board.line;
            if (near_row > 0 && $urandom_range(1)) near_row--;
            w.target_row = ROW_OUT_W'(near_row);
            w.target_col = COL_OUT_W'($urandom_range(SCREEN_COLS - 1));
         end else if (pick < 80) begin
            w.target_row = ROW_OUT_W'($urandom_range(SCREEN_LINES - 1));
            w.target_col = COL_OUT_W'($urandom_range(SCREEN_COLS - 1));
         end
      end else if (pick < 97) begin
         w.operation = OP_LOCATE;
         if ($urandom_range(99) < 80) begin
            w.target_row = ROW_OUT_W'($urandom_range(SCREEN_LINES - 1));
            w.target_col = COL_OUT_W'($urandom_range(SCREEN_COLS - 1));
         end
      end else begin
         w.operation = OP_CLEAR;
      end
      return w;
   endfunction

   task automatic send_word(console_req_type w);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_operation     <= w.operation;
      req_char_code     <= w.char_code;
      req_end_of_string <= w.end_of_string;
      req_add_newline   <= w.add_newline;
      req_target_row    <= w.target_row;
      req_target_col    <= w.target_col;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic write_register(logic [CSR_INDEX_W-1:0] index, logic [COLOR_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (board.reports_due.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   initial begin
      board = new();
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_word(word_of(OP_READ,   8'h00,    1'b0, 1'b0, 5'd0,  7'd0));
      send_word(word_of(OP_READ,   8'hff,    1'b1, 1'b1, 5'd31, 7'd127));
      send_word(word_of(OP_READ,   8'h00,    1'b0, 1'b0, 5'd25, 7'd0));
      send_word(word_of(OP_READ,   8'h00,    1'b0, 1'b0, 5'd0,  7'd80));
      send_word(word_of(OP_LOCATE, 8'h00,    1'b0, 1'b0, 5'd31, 7'd127));
      send_word(word_of(OP_LOCATE, 8'h00,    1'b0, 1'b0, 5'd25, 7'd0));
      send_word(word_of(OP_LOCATE, 8'h00,    1'b0, 1'b0, 5'd0,  7'd80));
      send_word(word_of(OP_CHAR,   8'h00,    1'b0, 1'b0, 5'd0,  7'd0));
      send_word(word_of(OP_CHAR,   8'hff,    1'b1, 1'b0, 5'd0,  7'd0));
      send_word(word_of(OP_CHAR,   CHAR_BS,  1'b0, 1'b0, 5'd0,  7'd0));
      send_word(word_of(OP_LOCATE, 8'h00,    1'b0, 1'b0, 5'd0,  7'd0));
      send_word(word_of(OP_CHAR,   CHAR_BS,  1'b0, 1'b0, 5'd0,  7'd0));
      send_word(word_of(OP_CHAR,   CHAR_TAB, 1'b0, 1'b0, 5'd0,  7'd0));
      send_word(word_of(OP_CHAR,   8'h78,    1'b0, 1'b1, 5'd0,  7'd0));
      send_word(word_of(OP_CHAR,   CHAR_TAB, 1'b0, 1'b0, 5'd0,  7'd0));
      send_word(word_of(OP_LOCATE, 8'h00,    1'b0, 1'b0, 5'd24, 7'd78));
      send_word(word_of(OP_CHAR,   8'h41,    1'b1, 1'b1, 5'd0,  7'd0));
      send_word(word_of(OP_LOCATE, 8'h00,    1'b0, 1'b0, 5'd24, 7'd79));
      send_word(word_of(OP_CHAR,   8'h5a,    1'b0, 1'b0, 5'd0,  7'd0));
      send_word(word_of(OP_READ,   8'h00,    1'b0, 1'b0, 5'd24, 7'd79));
      send_word(word_of(OP_CHAR,   CHAR_CR,  1'b0, 1'b0, 5'd0,  7'd0));
      send_word(word_of(OP_LOCATE, 8'h00,    1'b0, 1'b0, 5'd24, 7'd75));
      send_word(word_of(OP_CHAR,   CHAR_TAB, 1'b0, 1'b0, 5'd0,  7'd0));
      send_word(word_of(OP_CHAR,   CHAR_TAB, 1'b0, 1'b0, 5'd0,  7'd0));
      send_word(word_of(OP_CHAR,   CHAR_LF,  1'b0, 1'b0, 5'd0,  7'd0));
      send_word(word_of(OP_READ,   8'h00,    1'b0, 1'b0, 5'd21, 7'd79));
      send_word(word_of(OP_CLEAR,  8'h00,    1'b0, 1'b0, 5'd0,  7'd0));
      send_word(word_of(OP_READ,   8'h00,    1'b0, 1'b0, 5'd21, 7'd79));

      for (int p = 0; p < PHASES; p++) begin
         drain();
         write_register(REG_FOREGROUND, FG_LIST[p]);
         write_register(REG_BACKGROUND, BG_LIST[p]);
         idle_pct  = IDLE_PCT[p];
         stall_pct = STALL_PCT[p];
         if (p == PHASES - 1) hold_token++;
         repeat (PHASE_ITEMS) send_word(random_word());
      end
      drain();

      if (board.mismatches == 0) begin
         $display("** text_console_writer: PASSED **");
      end else begin
         $display("** text_console_writer: FAILED **");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
hdl/tcw_pkg.sv
hdl/tcw_front.sv
hdl/tcw_queue.sv
hdl/tcw_back.sv
hdl/text_console_writer.sv
tb/testbench.sv
